>>> hdl/murmur64a_hash_stream_top_defines.svh
// Assertion macros used by the hash stream controller RTL.
`ifndef MURMUR64A_HASH_STREAM_TOP_DEFINES_SVH
`define MURMUR64A_HASH_STREAM_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define MH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define MH_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("reset assertion failed");
`else
`define MH_ASSERT(lbl, prop)
`define MH_ASSERT_RST(lbl, prop)
`endif

`endif

>>> hdl/mh64_pkg.sv
// Package with constants, types and command structures of the hash stream block.
package mh64_pkg;

  localparam int LENGTH_WIDTH = 32;
  localparam logic [31:0] LEN_MASK = (LENGTH_WIDTH >= 32) ? 32'hffff_ffff :
                                     32'((64'd1 << LENGTH_WIDTH) - 64'd1);

  localparam logic [63:0] MUL_CONST = 64'hc6a4_a793_5bd1_e995;
  localparam logic [31:0] MUL_LO = MUL_CONST[31:0];
  localparam logic [31:0] MUL_HI = MUL_CONST[63:32];
  localparam int SHIFT_AMT = 47;
  localparam logic [7:0] BYTE_MASK = 8'hff;

  localparam logic [1:0] MUL_FIRST_PHASE = 2'd0;
  localparam logic [1:0] MUL_LAST_PHASE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_LOAD,
    ST_MUL,
    ST_POST
  } state_t;

  typedef enum logic [2:0] {
    STEP_SEED,
    STEP_KMUL1,
    STEP_KMUL2,
    STEP_HMUL,
    STEP_TAIL,
    STEP_FIN
  } step_t;

  typedef struct packed {
    logic       capture;
    logic       load_op;
    logic       mul_en;
    logic [1:0] phase;
    logic       hash_wr;
    logic       out_load;
    step_t      step;
  } mh64_cmd_t;

  typedef struct packed {
    logic first;
    logic last;
    logic full;
    logic tail;
  } mh64_stat_t;

endpackage

>>> hdl/mh64_in_if.sv
// Input channel interface carrying one message word per transfer.
interface mh64_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        first_word;
  logic        last_word;
  logic [31:0] message_length;

  modport source (output valid, data_word, byte_count, first_word, last_word,
                  message_length, input ready);
  modport sink (input valid, data_word, byte_count, first_word, last_word,
                message_length, output ready);
endinterface

>>> hdl/mh64_out_if.sv
// Result channel interface carrying one finished hash per transfer.
interface mh64_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink (input valid, hash_value, output ready);
endinterface

>>> hdl/murmur64a_hash_stream_top.sv
// Top level of the streaming MurmurHash64A block.
// The block hashes a message sent as little-endian 64-bit words, one word per input
// transfer, and sends one 64-bit hash per word marked last. A word is accepted only
// while the block is idle, so the next one waits until the n 64-bit multiplies by
// the constant that the word needs are done: one for seeding on a first word, three
// for a full word, one for a partial word and one for the final avalanche, so n is
// 0 to 5. Each multiply runs as three partial products through one 32x32 multiplier,
// bracketed by an operand load and a write-back cycle.
// A finished hash waits in an output register while the next message word is taken;
// only a second result blocks until the first transfer completes. The seed register
// may be written whenever no message word is in flight.
module murmur64a_hash_stream_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [63:0] cfg_data,
  mh64_in_if.sink     in_chan,
  mh64_out_if.source  out_chan
);

  mh64_pkg::mh64_cmd_t  cmd;
  mh64_pkg::mh64_stat_t stat;

  mh64_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mh64_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .data_word      (in_chan.data_word),
    .byte_count     (in_chan.byte_count),
    .first_word     (in_chan.first_word),
    .last_word      (in_chan.last_word),
    .message_length (in_chan.message_length),
    .cmd            (cmd),
    .stat           (stat),
    .hash_value     (out_chan.hash_value)
  );

endmodule

>>> hdl/mh64_dpath.sv
// Datapath: word capture, shared 32x32 multiplier, running hash and result register.
module mh64_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [63:0]        cfg_data,
  input  logic [63:0]        data_word,
  input  logic [3:0]         byte_count,
  input  logic               first_word,
  input  logic               last_word,
  input  logic [31:0]        message_length,
  input  mh64_pkg::mh64_cmd_t cmd,
  output mh64_pkg::mh64_stat_t stat,
  output logic [63:0]        hash_value
);

  logic [63:0] seed_r;
  logic [63:0] hash_r;
  logic [63:0] word_r;
  logic [31:0] len_r;
  logic [63:0] op_r;
  logic [63:0] acc_r;
  logic [63:0] out_r;
  mh64_pkg::mh64_stat_t stat_r;

  logic [63:0] keep;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [63:0] acc_nxt;
  logic [63:0] op_nxt;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      keep[i*8 +: 8] = (byte_count[3] || (4'(i) < byte_count)) ? mh64_pkg::BYTE_MASK : 8'h00;
    end
  end

  // A 64-bit product by the constant is built from three partial products.
  assign mul_a = (cmd.phase == 2'd1) ? op_r[63:32] : op_r[31:0];
  assign mul_b = (cmd.phase == mh64_pkg::MUL_LAST_PHASE) ? mh64_pkg::MUL_HI : mh64_pkg::MUL_LO;
  assign prod  = 64'(mul_a) * 64'(mul_b);
  assign acc_nxt = (cmd.phase == mh64_pkg::MUL_FIRST_PHASE) ? prod :
                   acc_r + {prod[31:0], 32'h0};

  always_comb begin
    unique case (cmd.step)
      mh64_pkg::STEP_SEED:  op_nxt = {32'h0, len_r};
      mh64_pkg::STEP_KMUL1: op_nxt = word_r;
      mh64_pkg::STEP_KMUL2: op_nxt = acc_r ^ (acc_r >> mh64_pkg::SHIFT_AMT);
      mh64_pkg::STEP_HMUL:  op_nxt = hash_r ^ acc_r;
      mh64_pkg::STEP_TAIL:  op_nxt = hash_r ^ word_r;
      mh64_pkg::STEP_FIN:   op_nxt = hash_r ^ (hash_r >> mh64_pkg::SHIFT_AMT);
      default:              op_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
      hash_r <= '0;
      stat_r <= '0;
    end else begin
      if (cfg_we) begin
        seed_r <= cfg_data;
      end
      if (cmd.hash_wr) begin
        hash_r <= (cmd.step == mh64_pkg::STEP_SEED) ? (seed_r ^ acc_r) : acc_r;
      end
      if (cmd.capture) begin
        stat_r.first <= first_word;
        stat_r.last  <= last_word;
        stat_r.full  <= byte_count[3];
        stat_r.tail  <= !byte_count[3] && (byte_count != 4'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      word_r <= data_word & keep;
      len_r  <= message_length & mh64_pkg::LEN_MASK;
    end
    if (cmd.load_op) begin
      op_r <= op_nxt;
    end
    if (cmd.mul_en) begin
      acc_r <= acc_nxt;
    end
    if (cmd.out_load) begin
      out_r <= acc_r ^ (acc_r >> mh64_pkg::SHIFT_AMT);
    end
  end

  assign stat = stat_r;
  assign hash_value = out_r;

endmodule

>>> hdl/mh64_ctrl.sv
// Controller: sequences capture, multiply steps, hash updates and result hand-off.
`include "murmur64a_hash_stream_top_defines.svh"

module mh64_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  mh64_pkg::mh64_stat_t stat,
  output mh64_pkg::mh64_cmd_t  cmd
);

  mh64_pkg::state_t state_r, state_nxt;
  mh64_pkg::step_t  step_r, step_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    phase_nxt = phase_r;
    unique case (state_r)
      mh64_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = mh64_pkg::ST_START;
        end
      end
      mh64_pkg::ST_START: begin
        state_nxt = mh64_pkg::ST_LOAD;
        priority if (stat.first) begin
          step_nxt = mh64_pkg::STEP_SEED;
        end else if (stat.full) begin
          step_nxt = mh64_pkg::STEP_KMUL1;
        end else if (stat.tail) begin
          step_nxt = mh64_pkg::STEP_TAIL;
        end else if (stat.last) begin
          step_nxt = mh64_pkg::STEP_FIN;
        end else begin
          state_nxt = mh64_pkg::ST_IDLE;
        end
      end
      mh64_pkg::ST_LOAD: begin
        state_nxt = mh64_pkg::ST_MUL;
        phase_nxt = mh64_pkg::MUL_FIRST_PHASE;
      end
      mh64_pkg::ST_MUL: begin
        if (phase_r == mh64_pkg::MUL_LAST_PHASE) begin
          state_nxt = mh64_pkg::ST_POST;
        end else begin
          phase_nxt = phase_r + 2'd1;
        end
      end
      mh64_pkg::ST_POST: begin
        unique case (step_r)
          mh64_pkg::STEP_SEED: begin
            state_nxt = mh64_pkg::ST_LOAD;
            priority if (stat.full) begin
              step_nxt = mh64_pkg::STEP_KMUL1;
            end else if (stat.tail) begin
              step_nxt = mh64_pkg::STEP_TAIL;
            end else if (stat.last) begin
              step_nxt = mh64_pkg::STEP_FIN;
            end else begin
              state_nxt = mh64_pkg::ST_IDLE;
            end
          end
          mh64_pkg::STEP_KMUL1: begin
            state_nxt = mh64_pkg::ST_LOAD;
            step_nxt  = mh64_pkg::STEP_KMUL2;
          end
          mh64_pkg::STEP_KMUL2: begin
            state_nxt = mh64_pkg::ST_LOAD;
            step_nxt  = mh64_pkg::STEP_HMUL;
          end
          mh64_pkg::STEP_HMUL, mh64_pkg::STEP_TAIL: begin
            if (stat.last) begin
              state_nxt = mh64_pkg::ST_LOAD;
              step_nxt  = mh64_pkg::STEP_FIN;
            end else begin
              state_nxt = mh64_pkg::ST_IDLE;
            end
          end
          mh64_pkg::STEP_FIN: begin
            if (out_free) begin
              state_nxt = mh64_pkg::ST_IDLE;
            end
          end
          default: state_nxt = mh64_pkg::ST_IDLE;
        endcase
      end
      default: state_nxt = mh64_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.step     = step_r;
    cmd.phase    = phase_r;
    cmd.capture  = (state_r == mh64_pkg::ST_IDLE) && in_valid;
    cmd.load_op  = (state_r == mh64_pkg::ST_LOAD);
    cmd.mul_en   = (state_r == mh64_pkg::ST_MUL);
    cmd.hash_wr  = (state_r == mh64_pkg::ST_POST) &&
                   ((step_r == mh64_pkg::STEP_SEED) || (step_r == mh64_pkg::STEP_HMUL) ||
                    (step_r == mh64_pkg::STEP_TAIL));
    cmd.out_load = (state_r == mh64_pkg::ST_POST) && (step_r == mh64_pkg::STEP_FIN) && out_free;
    in_ready     = (state_r == mh64_pkg::ST_IDLE);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mh64_pkg::ST_IDLE;
      step_r      <= mh64_pkg::STEP_SEED;
      phase_r     <= mh64_pkg::MUL_FIRST_PHASE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `MH_ASSERT(a_capture_starts, cmd.capture |=> state_r == mh64_pkg::ST_START)
  `MH_ASSERT(a_result_from_fin, $rose(out_valid_r) |->
    $past(state_r == mh64_pkg::ST_POST && step_r == mh64_pkg::STEP_FIN))
  `MH_ASSERT(a_mul_advance, (state_r == mh64_pkg::ST_MUL && phase_r != mh64_pkg::MUL_LAST_PHASE)
    |=> (state_r == mh64_pkg::ST_MUL && phase_r == $past(phase_r) + 2'd1))
  `MH_ASSERT(a_load_to_mul, state_r == mh64_pkg::ST_LOAD |=>
    (state_r == mh64_pkg::ST_MUL && phase_r == mh64_pkg::MUL_FIRST_PHASE))
  `MH_ASSERT_RST(a_reset_idle, !rst_n |=> (state_r == mh64_pkg::ST_IDLE && !out_valid_r))

endmodule
